/* sv/ordered_record_table_macros.svh */
// Assertion helpers for the checker file
`ifndef ORDERED_RECORD_TABLE_MACROS_SVH
`define ORDERED_RECORD_TABLE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define ORT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define ORT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ort_pkg.sv */
package ort_pkg;

    // Fixed port geometry
    localparam int WORD_W     = 64;
    localparam int NAME_WORDS = 4;
    localparam int CITY_WORDS = 3;
    localparam int AGE_W      = 8;
    localparam int NAME_MAX_W = NAME_WORDS * WORD_W;
    localparam int CITY_MAX_W = CITY_WORDS * WORD_W;

    // Default sizing
    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_NAME_BYTES = 32;
    localparam int DEF_CITY_BYTES = 24;

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_FIND   = 2'd2,
        REQ_LIST   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // Controller to datapath commands
    typedef struct packed {
        logic    load_key;
        logic    idx_clr;
        logic    idx_inc;
        logic    rd_next;
        logic    wr_key;
        logic    wr_shift;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    emit;
        logic    emit_rec;
        logic    emit_last;
        t_status emit_status;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic full;
        logic at_end;
        logic last_entry;
        logic shift_done;
        logic age_hit;
        logic name_hit;
    } t_stat;

endpackage

/* sv/ort_ctrl.sv */
module ort_ctrl import ort_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_req_type,
    input  t_stat      i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPEND,
        S_RD,
        S_CHK,
        S_SH_RD,
        S_SH_WR
    } t_state;

    t_state r_state, n_state;
    t_req   r_req, n_req;
    logic   r_busy;
    t_cmd   cmd;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        cmd     = '0;
        cmd.emit_status = ST_DONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load_key = 1'b1;
                    cmd.idx_clr  = 1'b1;
                    n_req        = t_req'(i_req_type);
                    n_state      = (t_req'(i_req_type) == REQ_APPEND) ? S_APPEND : S_RD;
                end
            end
            S_APPEND: begin
                cmd.emit      = 1'b1;
                cmd.emit_last = 1'b1;
                if (i_stat.full) begin
                    cmd.emit_status = ST_FULL;
                end else begin
                    cmd.wr_key  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                end
                n_state = S_IDLE;
            end
            S_RD: begin
                // ran off the end: miss, or an empty list
                if (i_stat.at_end) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_last   = 1'b1;
                    cmd.emit_status = (r_req == REQ_LIST) ? ST_EMPTY : ST_NOT_FOUND;
                    n_state         = S_IDLE;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                unique case (r_req)
                    REQ_DELETE: begin
                        if (i_stat.age_hit) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_rec  = 1'b1;
                            cmd.emit_last = 1'b1;
                            n_state       = S_SH_RD;
                        end else begin
                            cmd.idx_inc = 1'b1;
                            n_state     = S_RD;
                        end
                    end
                    REQ_FIND: begin
                        if (i_stat.name_hit) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_rec  = 1'b1;
                            cmd.emit_last = 1'b1;
                            n_state       = S_IDLE;
                        end else begin
                            cmd.idx_inc = 1'b1;
                            n_state     = S_RD;
                        end
                    end
                    REQ_LIST: begin
                        cmd.emit      = 1'b1;
                        cmd.emit_rec  = 1'b1;
                        cmd.emit_last = i_stat.last_entry;
                        cmd.idx_inc   = 1'b1;
                        n_state       = i_stat.last_entry ? S_IDLE : S_RD;
                    end
                    REQ_APPEND: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SH_RD: begin
                // close the gap one entry at a time
                if (i_stat.shift_done) begin
                    cmd.cnt_dec = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    cmd.rd_next = 1'b1;
                    n_state     = S_SH_WR;
                end
            end
            S_SH_WR: begin
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
                n_state      = S_SH_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_req   <= REQ_APPEND;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_req   <= n_req;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = r_busy;

endmodule

/* sv/ort_datapath.sv */
module ort_datapath import ort_pkg::*; #(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int NAME_BYTES = DEF_NAME_BYTES,
    parameter int CITY_BYTES = DEF_CITY_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [WORD_W-1:0] i_name_w0,
    input  logic [WORD_W-1:0] i_name_w1,
    input  logic [WORD_W-1:0] i_name_w2,
    input  logic [WORD_W-1:0] i_name_w3,
    input  logic [WORD_W-1:0] i_city_w0,
    input  logic [WORD_W-1:0] i_city_w1,
    input  logic [WORD_W-1:0] i_city_w2,
    input  logic [AGE_W-1:0]  i_age_in,
    output t_stat             o_stat,
    output logic              o_valid,
    output logic [1:0]        o_status,
    output logic [WORD_W-1:0] o_rec_name_w0,
    output logic [WORD_W-1:0] o_rec_name_w1,
    output logic [WORD_W-1:0] o_rec_name_w2,
    output logic [WORD_W-1:0] o_rec_name_w3,
    output logic [WORD_W-1:0] o_rec_city_w0,
    output logic [WORD_W-1:0] o_rec_city_w1,
    output logic [WORD_W-1:0] o_rec_city_w2,
    output logic [AGE_W-1:0]  o_rec_age,
    output logic              o_last_result
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int NB = NAME_BYTES * 8;
    localparam int CB = CITY_BYTES * 8;
    localparam int RW = NB + CB + AGE_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [NB-1:0]         r_key_name;
    logic [CB-1:0]         r_key_city;
    logic [AGE_W-1:0]      r_key_age;
    logic [CW-1:0]         r_idx;
    logic [CW-1:0]         r_count;
    logic [RW-1:0]         r_mem [CAPACITY];
    logic [RW-1:0]         r_rdata;
    logic                  r_valid;
    t_status               r_status;
    logic [NAME_MAX_W-1:0] r_name;
    logic [CITY_MAX_W-1:0] r_city;
    logic [AGE_W-1:0]      r_age;
    logic                  r_last;

    logic [NAME_MAX_W-1:0] name_in;
    logic [CITY_MAX_W-1:0] city_in;
    logic [CW-1:0]         idx_next;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic [RW-1:0]         wr_data;
    logic                  wr_en;
    logic [NB-1:0]         rec_name;
    logic [CB-1:0]         rec_city;
    logic [AGE_W-1:0]      rec_age;

    // Bytes beyond the configured lengths are dropped at key capture
    assign name_in = {i_name_w3, i_name_w2, i_name_w1, i_name_w0};
    assign city_in = {i_city_w2, i_city_w1, i_city_w0};

    // Record layout: {age, city, name}
    assign rec_name = r_rdata[NB-1:0];
    assign rec_city = r_rdata[NB+CB-1:NB];
    assign rec_age  = r_rdata[RW-1:NB+CB];

    // Address selection
    assign idx_next = r_idx + CW'(1);
    assign rd_addr  = i_cmd.rd_next ? idx_next[AW-1:0] : r_idx[AW-1:0];
    assign wr_en    = i_cmd.wr_key | i_cmd.wr_shift;
    assign wr_addr  = i_cmd.wr_key ? r_count[AW-1:0] : r_idx[AW-1:0];
    assign wr_data  = i_cmd.wr_key ? {r_key_age, r_key_city, r_key_name} : r_rdata;

    // Status towards the controller
    assign o_stat.full       = (r_count == CAP_C);
    assign o_stat.at_end     = (r_idx == r_count);
    assign o_stat.last_entry = (idx_next == r_count);
    assign o_stat.shift_done = (idx_next >= r_count);
    assign o_stat.age_hit    = (rec_age == r_key_age);
    assign o_stat.name_hit   = (rec_name == r_key_name);

    // Record store, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // Request key capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_key) begin
            r_key_name <= name_in[NB-1:0];
            r_key_city <= city_in[CB-1:0];
            r_key_age  <= i_age_in;
        end
    end

    // Scan index and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= idx_next;
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    // Result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status <= i_cmd.emit_status;
            r_last   <= i_cmd.emit_last;
            if (i_cmd.emit_rec) begin
                r_name <= NAME_MAX_W'(rec_name);
                r_city <= CITY_MAX_W'(rec_city);
                r_age  <= rec_age;
            end else begin
                r_name <= '0;
                r_city <= '0;
                r_age  <= '0;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_rec_name_w0 = r_name[WORD_W-1:0];
    assign o_rec_name_w1 = r_name[2*WORD_W-1:WORD_W];
    assign o_rec_name_w2 = r_name[3*WORD_W-1:2*WORD_W];
    assign o_rec_name_w3 = r_name[4*WORD_W-1:3*WORD_W];
    assign o_rec_city_w0 = r_city[WORD_W-1:0];
    assign o_rec_city_w1 = r_city[2*WORD_W-1:WORD_W];
    assign o_rec_city_w2 = r_city[3*WORD_W-1:2*WORD_W];
    assign o_rec_age     = r_age;
    assign o_last_result = r_last;

endmodule

/* sv/ordered_record_table.sv */
// Ordered record table. A request word is taken when start is high and busy is low; busy
// then stays high until the request is finished. Results appear one cycle each, marked
// by o_valid, and cannot be held off: the receiver must take every result on the cycle
// it is shown. Records sit in a single-port-read memory with a registered read, so each
// entry visited goes through a read state and then a check state. An append finishes in
// a single state; a delete, after its hit, moves every later entry up one place with a
// read and a write each; a list gives one result per record. The default capacity is 16
// records. The record memory is not cleared after reset: entries are only read once
// they have been written.
module ordered_record_table import ort_pkg::*; #(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int NAME_BYTES = DEF_NAME_BYTES,
    parameter int CITY_BYTES = DEF_CITY_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_req_type,
    input  logic [WORD_W-1:0] i_name_w0,
    input  logic [WORD_W-1:0] i_name_w1,
    input  logic [WORD_W-1:0] i_name_w2,
    input  logic [WORD_W-1:0] i_name_w3,
    input  logic [WORD_W-1:0] i_city_w0,
    input  logic [WORD_W-1:0] i_city_w1,
    input  logic [WORD_W-1:0] i_city_w2,
    input  logic [AGE_W-1:0]  i_age_in,
    output logic              o_valid,
    output logic [1:0]        o_status,
    output logic [WORD_W-1:0] o_rec_name_w0,
    output logic [WORD_W-1:0] o_rec_name_w1,
    output logic [WORD_W-1:0] o_rec_name_w2,
    output logic [WORD_W-1:0] o_rec_name_w3,
    output logic [WORD_W-1:0] o_rec_city_w0,
    output logic [WORD_W-1:0] o_rec_city_w1,
    output logic [WORD_W-1:0] o_rec_city_w2,
    output logic [AGE_W-1:0]  o_rec_age,
    output logic              o_last_result
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencer
    ort_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    // Record store, key registers and result register
    ort_datapath #(
        .CAPACITY   (CAPACITY),
        .NAME_BYTES (NAME_BYTES),
        .CITY_BYTES (CITY_BYTES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_name_w0     (i_name_w0),
        .i_name_w1     (i_name_w1),
        .i_name_w2     (i_name_w2),
        .i_name_w3     (i_name_w3),
        .i_city_w0     (i_city_w0),
        .i_city_w1     (i_city_w1),
        .i_city_w2     (i_city_w2),
        .i_age_in      (i_age_in),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_rec_name_w0 (o_rec_name_w0),
        .o_rec_name_w1 (o_rec_name_w1),
        .o_rec_name_w2 (o_rec_name_w2),
        .o_rec_name_w3 (o_rec_name_w3),
        .o_rec_city_w0 (o_rec_city_w0),
        .o_rec_city_w1 (o_rec_city_w1),
        .o_rec_city_w2 (o_rec_city_w2),
        .o_rec_age     (o_rec_age),
        .o_last_result (o_last_result)
    );

endmodule

/* sv/ort_checker.sv */
`include "ordered_record_table_macros.svh"

module ort_checker import ort_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input logic [1:0]        o_status,
    input logic [WORD_W-1:0] o_rec_name_w0,
    input logic [AGE_W-1:0]  o_rec_age,
    input logic              o_last_result
);

    // An accepted word keeps the block busy on the following cycle
    `ORT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "busy not raised after accept")

    // More results still to come means the request is still running
    `ORT_ASSERT_SAME(a_more_busy, i_clk, i_rst_n, o_valid && !o_last_result, busy, "idle with results pending")

    // Only list hits give several results, so miss, full and empty results are always last
    `ORT_ASSERT_SAME(a_fail_last, i_clk, i_rst_n, o_valid && o_status != ST_DONE, o_last_result, "error result not last")

    // Miss, full and empty results carry no record
    `ORT_ASSERT_SAME(a_fail_zero, i_clk, i_rst_n, o_valid && (o_status == ST_NOT_FOUND || o_status == ST_FULL || o_status == ST_EMPTY), o_rec_age == '0 && o_rec_name_w0 == '0, "record on error result")

endmodule

bind ordered_record_table ort_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_status      (o_status),
    .o_rec_name_w0 (o_rec_name_w0),
    .o_rec_age     (o_rec_age),
    .o_last_result (o_last_result)
);

/* dv/tb_ordered_record_table.sv */
`timescale 1ns / 1ps

module tb_ordered_record_table;
    import ort_pkg::*;

    localparam int TABLE_DEPTH  = DEF_CAPACITY;
    localparam int DRAIN_CYCLES = 80;
    localparam int ROUND_ITEMS  = 44;

    // One stored person, laid out as on the ports: word k of a field in bits 64k+63..64k
    typedef struct packed {
        logic [NAME_MAX_W-1:0] name;
        logic [CITY_MAX_W-1:0] city;
        logic [AGE_W-1:0]      age;
    } t_person;

    // One result word as the block should show it
    typedef struct packed {
        logic [1:0]  status;
        t_person     rec;
        logic        is_last;
    } t_result_word;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_req_type;
    logic [WORD_W-1:0] i_name_w0, i_name_w1, i_name_w2, i_name_w3;
    logic [WORD_W-1:0] i_city_w0, i_city_w1, i_city_w2;
    logic [AGE_W-1:0]  i_age_in;
    logic              o_valid;
    logic [1:0]        o_status;
    logic [WORD_W-1:0] o_rec_name_w0, o_rec_name_w1, o_rec_name_w2, o_rec_name_w3;
    logic [WORD_W-1:0] o_rec_city_w0, o_rec_city_w1, o_rec_city_w2;
    logic [AGE_W-1:0]  o_rec_age;
    logic              o_last_result;

    // Mirror of the table contents and the results still owed by the block
    t_person      table_rows [TABLE_DEPTH];
    int           row_count;
    t_result_word expected_results [$];

    int mismatches;
    int requests_sent;
    int results_checked;
    int full_rejects;
    int search_hits;
    int search_misses;

    ordered_record_table u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_name_w0     (i_name_w0),
        .i_name_w1     (i_name_w1),
        .i_name_w2     (i_name_w2),
        .i_name_w3     (i_name_w3),
        .i_city_w0     (i_city_w0),
        .i_city_w1     (i_city_w1),
        .i_city_w2     (i_city_w2),
        .i_age_in      (i_age_in),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_rec_name_w0 (o_rec_name_w0),
        .o_rec_name_w1 (o_rec_name_w1),
        .o_rec_name_w2 (o_rec_name_w2),
        .o_rec_name_w3 (o_rec_name_w3),
        .o_rec_city_w0 (o_rec_city_w0),
        .o_rec_city_w1 (o_rec_city_w1),
        .o_rec_city_w2 (o_rec_city_w2),
        .o_rec_age     (o_rec_age),
        .o_last_result (o_last_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ---------------------------------------------------------------- helpers

    function automatic t_person make_person(input logic [NAME_MAX_W-1:0] name,
                                            input logic [CITY_MAX_W-1:0] city,
                                            input logic [AGE_W-1:0] age);
        t_person p;
        p.name = name;
        p.city = city;
        p.age  = age;
        return p;
    endfunction

    // ASCII text, first character in the lowest byte, zero-padded
    function automatic logic [NAME_MAX_W-1:0] pack_text(input string s);
        logic [NAME_MAX_W-1:0] v;
        v = '0;
        for (int k = 0; k < s.len() && k < NAME_MAX_W / 8; k++)
            v[8*k +: 8] = s[k];
        return v;
    endfunction

    function automatic logic [NAME_MAX_W-1:0] rand_bits();
        logic [NAME_MAX_W-1:0] v;
        for (int k = 0; k < NAME_MAX_W / 32; k++)
            v[32*k +: 32] = $urandom;
        return v;
    endfunction

    // Either fully random bytes or a random head followed by zero padding
    function automatic t_person random_person();
        t_person               p;
        logic [NAME_MAX_W-1:0] bits;
        int                    len;
        bits = rand_bits();
        len  = $urandom_range(1, NAME_MAX_W / 8 - 1);
        p.name = ($urandom_range(0, 2) == 0) ? bits : bits & ~({NAME_MAX_W{1'b1}} << (8 * len));
        bits = rand_bits();
        len  = $urandom_range(1, CITY_MAX_W / 8 - 1);
        p.city = ($urandom_range(0, 1) == 0) ? bits[CITY_MAX_W-1:0]
                                             : bits[CITY_MAX_W-1:0]
                                               & ~({CITY_MAX_W{1'b1}} << (8 * len));
        // mostly a narrow band so that duplicate ages are common
        p.age = ($urandom_range(0, 9) < 7) ? AGE_W'($urandom_range(20, 25))
                                           : AGE_W'($urandom_range(0, 255));
        return p;
    endfunction

    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 70);
    endfunction

    // ---------------------------------------------------------------- predictor

    function automatic void owe_result(input t_status status, input t_person rec,
                                       input logic is_last);
        t_result_word w;
        w.status  = status;
        w.rec     = rec;
        w.is_last = is_last;
        expected_results.push_back(w);
    endfunction

    // Applies one accepted request to the mirror and queues the words it causes
    task automatic predict_request(input t_req req, input t_person p);
        t_person blank;
        int      hit;
        blank = '0;
        hit   = -1;
        case (req)
            REQ_APPEND: begin
                if (row_count >= TABLE_DEPTH) begin
                    full_rejects++;
                    owe_result(ST_FULL, blank, 1'b1);
                end else begin
                    table_rows[row_count] = p;
                    row_count++;
                    owe_result(ST_DONE, blank, 1'b1);
                end
            end
            REQ_DELETE: begin
                for (int k = row_count - 1; k >= 0; k--)
                    if (table_rows[k].age == p.age) hit = k;
                if (hit < 0) begin
                    search_misses++;
                    owe_result(ST_NOT_FOUND, blank, 1'b1);
                end else begin
                    search_hits++;
                    owe_result(ST_DONE, table_rows[hit], 1'b1);
                    // close the gap, keeping order
                    for (int k = hit; k + 1 < row_count; k++)
                        table_rows[k] = table_rows[k + 1];
                    row_count--;
                end
            end
            REQ_FIND: begin
                for (int k = row_count - 1; k >= 0; k--)
                    if (table_rows[k].name == p.name) hit = k;
                if (hit < 0) begin
                    search_misses++;
                    owe_result(ST_NOT_FOUND, blank, 1'b1);
                end else begin
                    search_hits++;
                    owe_result(ST_DONE, table_rows[hit], 1'b1);
                end
            end
            default: begin
                if (row_count == 0)
                    owe_result(ST_EMPTY, blank, 1'b1);
                else
                    for (int k = 0; k < row_count; k++)
                        owe_result(ST_DONE, table_rows[k], k == row_count - 1);
            end
        endcase
    endtask

    // ---------------------------------------------------------------- driving

    // Holds the word on the ports until the block takes it; start stays high on return
    task automatic send_request(input t_req req, input t_person p);
        @(negedge i_clk);
        start      <= 1'b1;
        i_req_type <= req;
        i_name_w0  <= p.name[0*WORD_W +: WORD_W];
        i_name_w1  <= p.name[1*WORD_W +: WORD_W];
        i_name_w2  <= p.name[2*WORD_W +: WORD_W];
        i_name_w3  <= p.name[3*WORD_W +: WORD_W];
        i_city_w0  <= p.city[0*WORD_W +: WORD_W];
        i_city_w1  <= p.city[1*WORD_W +: WORD_W];
        i_city_w2  <= p.city[2*WORD_W +: WORD_W];
        i_age_in   <= p.age;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        predict_request(req, p);
        requests_sent++;
    endtask

    task automatic pause(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_spaced(input t_req req, input t_person p);
        send_request(req, p);
        pause(gap_cycles());
    endtask

    // ---------------------------------------------------------------- checking

    task automatic check_field(input string field, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result_word want;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $error("result word with nothing expected: status %0d", o_status);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                check_field("status",      WORD_W'(want.status),  WORD_W'(o_status));
                check_field("rec_name_w0", want.rec.name[0*WORD_W +: WORD_W], o_rec_name_w0);
                check_field("rec_name_w1", want.rec.name[1*WORD_W +: WORD_W], o_rec_name_w1);
                check_field("rec_name_w2", want.rec.name[2*WORD_W +: WORD_W], o_rec_name_w2);
                check_field("rec_name_w3", want.rec.name[3*WORD_W +: WORD_W], o_rec_name_w3);
                check_field("rec_city_w0", want.rec.city[0*WORD_W +: WORD_W], o_rec_city_w0);
                check_field("rec_city_w1", want.rec.city[1*WORD_W +: WORD_W], o_rec_city_w1);
                check_field("rec_city_w2", want.rec.city[2*WORD_W +: WORD_W], o_rec_city_w2);
                check_field("rec_age",     WORD_W'(want.rec.age),  WORD_W'(o_rec_age));
                check_field("last_result", WORD_W'(want.is_last), WORD_W'(o_last_result));
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // List, delete and find requests against a table that holds nothing
    task automatic test_empty_table();
        send_spaced(REQ_LIST,   random_person());
        send_spaced(REQ_DELETE, make_person('0, '0, '0));
        send_spaced(REQ_FIND,   make_person('0, '0, '0));
    endtask

    // All-ones, all-zero and alternating field values
    task automatic test_field_extremes();
        send_spaced(REQ_APPEND, make_person('1, '1, 8'hFF));
        send_spaced(REQ_APPEND, make_person('0, '0, 8'h00));
        send_spaced(REQ_APPEND, make_person({NAME_MAX_W/8{8'hAA}}, {CITY_MAX_W/8{8'h55}}, 8'h80));
        send_spaced(REQ_LIST,   random_person());
    endtask

    // First match wins, padding bytes count in the name compare, misses
    task automatic test_search_rules();
        logic [NAME_MAX_W-1:0] ann;
        logic [NAME_MAX_W-1:0] ann_junk;
        ann      = pack_text("ANN");
        ann_junk = ann | (NAME_MAX_W'(8'h5A) << (8 * 10));
        send_spaced(REQ_APPEND, make_person(ann, pack_text("OSLO"), 8'd30));
        send_spaced(REQ_APPEND, make_person(ann_junk, pack_text("LIMA"), 8'd30));
        send_spaced(REQ_FIND,   make_person(ann, '0, '0));
        send_spaced(REQ_FIND,   make_person(ann_junk, '0, '0));
        send_spaced(REQ_FIND,   make_person(ann | (NAME_MAX_W'(8'h01) << (8 * 31)), '0, '0));
        send_spaced(REQ_DELETE, make_person('0, '0, 8'd30));
        send_spaced(REQ_FIND,   make_person(ann, '0, '0));
        send_spaced(REQ_DELETE, make_person('0, '0, 8'd99));
        send_spaced(REQ_FIND,   make_person('0, '0, '0));
    endtask

    // Fill to capacity, bounce appends off the full table, then work at the edges
    task automatic test_full_table();
        t_person tail;
        while (row_count < TABLE_DEPTH)
            send_spaced(REQ_APPEND, random_person());
        send_spaced(REQ_APPEND, random_person());
        send_spaced(REQ_APPEND, random_person());
        send_spaced(REQ_LIST,   random_person());
        tail = table_rows[TABLE_DEPTH - 1];
        send_spaced(REQ_FIND,   make_person(tail.name, '0, '0));
        send_spaced(REQ_DELETE, make_person('0, '0, table_rows[0].age));
        send_spaced(REQ_APPEND, random_person());
        send_spaced(REQ_LIST,   random_person());
    endtask

    // Alternating fill-heavy and drain-heavy rounds with searches that mostly hit
    task automatic test_random_traffic();
        t_person p;
        t_req    req;
        int      r;
        bit      back_to_back;
        back_to_back = 1'b0;
        for (int round = 0; round < 4; round++) begin
            for (int n = 0; n < ROUND_ITEMS; n++) begin
                if (n % 11 == 0) back_to_back = ($urandom_range(0, 2) == 0);
                p = random_person();
                r = $urandom_range(0, 99);
                if (round % 2 == 0)
                    req = (r < 55) ? REQ_APPEND : (r < 70) ? REQ_DELETE
                        : (r < 90) ? REQ_FIND : REQ_LIST;
                else
                    req = (r < 20) ? REQ_APPEND : (r < 60) ? REQ_DELETE
                        : (r < 88) ? REQ_FIND : REQ_LIST;
                // steer keys towards stored records, sometimes one bit off
                if (row_count > 0 && $urandom_range(0, 3) != 0) begin
                    r = $urandom_range(0, row_count - 1);
                    p.age = table_rows[r].age;
                    p.name = table_rows[r].name;
                    if ($urandom_range(0, 2) == 0)
                        p.name[$urandom_range(0, NAME_MAX_W - 1)] ^= 1'b1;
                end
                send_request(req, p);
                if (!back_to_back) pause(gap_cycles());
            end
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_req_type = REQ_APPEND;
        i_name_w0  = '0;
        i_name_w1  = '0;
        i_name_w2  = '0;
        i_name_w3  = '0;
        i_city_w0  = '0;
        i_city_w1  = '0;
        i_city_w2  = '0;
        i_age_in   = '0;
        row_count       = 0;
        mismatches      = 0;
        requests_sent   = 0;
        results_checked = 0;
        full_rejects    = 0;
        search_hits     = 0;
        search_misses   = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_field_extremes();
        test_search_rules();
        test_full_table();
        test_random_traffic();
        pause(1);

        // let the last request finish, then watch for stray words
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests giving %0d result words, %0d appends refused as full,",
                 requests_sent, results_checked, full_rejects);
        $display("%0d delete/find hits and %0d misses.", search_hits, search_misses);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/ort_pkg.sv
sv/ort_ctrl.sv
sv/ort_datapath.sv
sv/ordered_record_table.sv
sv/ort_checker.sv
dv/tb_ordered_record_table.sv
